>>> hdl/kabf_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and saturation helpers for the angle and bias filter.
package kabf_pkg;

    // Datapath widths.
    localparam int ACC_W  = 56;   // wide signed accumulator for sums before saturation
    localparam int OP_W   = 35;   // signed multiplier operand
    localparam int MAG_W  = 34;   // multiplier operand magnitude
    localparam int PROD_W = 2 * MAG_W;
    localparam int FRAC_W = 16;   // fraction bits dropped after a product
    localparam int RES_W  = PROD_W - FRAC_W + 1;
    localparam int NUM_W  = 33;   // signed gain numerator
    localparam int DEN_W  = 33;   // unsigned gain denominator
    localparam int DIV_W  = NUM_W + FRAC_W;  // dividend and quotient width
    localparam int PER_W  = 17;

    // Reset values of the configuration registers and covariance.
    localparam logic [PER_W-1:0] PERIOD_RST = 17'd655;
    localparam logic [31:0] ANGLE_Q_RST = 32'd16777;
    localparam logic [31:0] BIAS_Q_RST  = 32'd16777;
    localparam logic [31:0] MEAS_R_RST  = 32'd335544320;
    localparam logic [31:0] ONE_Q8_24   = 32'd16777216;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PERIOD  = 2'd0,
        REG_ANGLE_Q = 2'd1,
        REG_BIAS_Q  = 2'd2,
        REG_MEAS_R  = 2'd3
    } cfg_index_t;

    // Configuration register set.
    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [31:0]      angle_q;
        logic [31:0]      bias_q;
        logic [31:0]      meas_r;
    } cfg_t;

    // Result of the serial multiplier.
    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] res;
    } mul_rsp_t;

    // Result of the serial divider.
    typedef struct packed {
        logic               done;
        logic signed [31:0] res;
    } div_rsp_t;

    // Sequencer steps.
    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_M_RATE  = 16'h0002,
        ST_M_T11   = 16'h0004,
        ST_M_CROSS = 16'h0008,
        ST_M_DT11  = 16'h0010,
        ST_ADD     = 16'h0020,
        ST_PREP    = 16'h0040,
        ST_D_K0    = 16'h0080,
        ST_D_K1    = 16'h0100,
        ST_M_ANG   = 16'h0200,
        ST_M_BIAS  = 16'h0400,
        ST_M_P00   = 16'h0800,
        ST_M_P01   = 16'h1000,
        ST_M_P10   = 16'h2000,
        ST_M_P11   = 16'h4000,
        ST_OUT     = 16'h8000
    } seq_state_t;

    // Sign extension of a 32-bit signed value to accumulator width.
    function automatic logic signed [ACC_W-1:0] sx32(input logic signed [31:0] v);
        return ACC_W'(v);
    endfunction

    // Zero extension of a 32-bit unsigned value to accumulator width.
    function automatic logic signed [ACC_W-1:0] zx32(input logic [31:0] v);
        return {{(ACC_W-32){1'b0}}, v};
    endfunction

    // Sign extension of a multiplier result to accumulator width.
    function automatic logic signed [ACC_W-1:0] sxr(input logic signed [RES_W-1:0] v);
        return ACC_W'(v);
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat_s32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if ((v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1))
            r = v[31:0];
        else if (v[ACC_W-1])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    // Clamp to the unsigned 32-bit range.
    function automatic logic [31:0] sat_u32(input logic signed [ACC_W-1:0] v);
        logic [31:0] r;
        if (v[ACC_W-1])
            r = '0;
        else if (|v[ACC_W-2:32])
            r = '1;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hdl/kalman_angle_bias_filter.sv
`timescale 1ns / 1ps
// Two-state angle and gyro bias filter: handshakes, configuration and step sequencer.
// Each accepted beat runs one filter step. Ten products go one after another through a
// single bit-serial multiplier, and the two gains go through a single bit-serial divider.
// The IDLE, ADD, PREP and OUT states accept the beat, add the process noise, form the gain
// denominator and load the output register. The next input beat is taken as soon as the
// step's result has been moved into the output register, even while that result is still
// stalled. Configuration writes are always taken; they should be made only while no step is
// under way.
module kalman_angle_bias_filter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] rate_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] angle_estimate,
    output logic signed [31:0] corrected_rate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    kabf_pkg::seq_state_t state_reg, state_next;
    logic launched_reg, launched_next;
    kabf_pkg::cfg_t cfg_reg;

    logic signed [31:0] z_reg, z_next, rate_reg, rate_next;
    logic signed [31:0] angle_reg, angle_next, bias_reg, bias_next;
    logic [31:0] p00_reg, p00_next, p11_reg, p11_next;
    logic signed [31:0] p01_reg, p01_next, p10_reg, p10_next;
    logic signed [31:0] angle_p_reg, angle_p_next;
    logic signed [kabf_pkg::OP_W-1:0] t11_reg, t11_next;
    logic signed [kabf_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [31:0] q00_reg, q00_next, q11_reg, q11_next;
    logic signed [31:0] q01_reg, q01_next, q10_reg, q10_next;
    logic [kabf_pkg::DEN_W-1:0] s_reg, s_next;
    logic signed [32:0] innov_reg, innov_next;
    logic signed [31:0] k0_reg, k0_next, k1_reg, k1_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] out_angle_reg, out_angle_next, out_rate_reg, out_rate_next;

    logic mul_start, div_start, is_mul, is_div;
    logic signed [kabf_pkg::OP_W-1:0] mul_a, mul_b, dt_op;
    logic signed [kabf_pkg::NUM_W-1:0] div_num;
    kabf_pkg::mul_rsp_t mul_rsp;
    kabf_pkg::div_rsp_t div_rsp;
    logic signed [kabf_pkg::ACC_W-1:0] mres;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period  <= kabf_pkg::PERIOD_RST;
            cfg_reg.angle_q <= kabf_pkg::ANGLE_Q_RST;
            cfg_reg.bias_q  <= kabf_pkg::BIAS_Q_RST;
            cfg_reg.meas_r  <= kabf_pkg::MEAS_R_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kabf_pkg::REG_PERIOD:  cfg_reg.period  <= cfg_data[kabf_pkg::PER_W-1:0];
                kabf_pkg::REG_ANGLE_Q: cfg_reg.angle_q <= cfg_data;
                kabf_pkg::REG_BIAS_Q:  cfg_reg.bias_q  <= cfg_data;
                kabf_pkg::REG_MEAS_R:  cfg_reg.meas_r  <= cfg_data;
                default:               cfg_reg.meas_r  <= cfg_reg.meas_r;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Operand selection for the shared multiplier and divider.
    always_comb
    begin
        dt_op   = signed'(kabf_pkg::OP_W'(cfg_reg.period));
        mul_a   = '0;
        mul_b   = '0;
        is_mul  = 1'b1;
        is_div  = 1'b0;
        div_num = '0;
        unique case (state_reg)
            kabf_pkg::ST_M_RATE:
            begin
                mul_a = dt_op;
                mul_b = kabf_pkg::OP_W'(rate_reg) - kabf_pkg::OP_W'(bias_reg);
            end
            kabf_pkg::ST_M_T11:
            begin
                mul_a = dt_op;
                mul_b = signed'(kabf_pkg::OP_W'(p11_reg));
            end
            kabf_pkg::ST_M_CROSS:
            begin
                mul_a = dt_op;
                mul_b = kabf_pkg::OP_W'(p01_reg) + kabf_pkg::OP_W'(p10_reg);
            end
            kabf_pkg::ST_M_DT11:
            begin
                mul_a = dt_op;
                mul_b = t11_reg;
            end
            kabf_pkg::ST_M_ANG:
            begin
                mul_a = kabf_pkg::OP_W'(k0_reg);
                mul_b = kabf_pkg::OP_W'(innov_reg);
            end
            kabf_pkg::ST_M_BIAS:
            begin
                mul_a = kabf_pkg::OP_W'(k1_reg);
                mul_b = kabf_pkg::OP_W'(innov_reg);
            end
            kabf_pkg::ST_M_P00:
            begin
                mul_a = kabf_pkg::OP_W'(k0_reg);
                mul_b = signed'(kabf_pkg::OP_W'(q00_reg));
            end
            kabf_pkg::ST_M_P01:
            begin
                mul_a = kabf_pkg::OP_W'(k0_reg);
                mul_b = kabf_pkg::OP_W'(q01_reg);
            end
            kabf_pkg::ST_M_P10:
            begin
                mul_a = kabf_pkg::OP_W'(k1_reg);
                mul_b = signed'(kabf_pkg::OP_W'(q00_reg));
            end
            kabf_pkg::ST_M_P11:
            begin
                mul_a = kabf_pkg::OP_W'(k1_reg);
                mul_b = kabf_pkg::OP_W'(q01_reg);
            end
            kabf_pkg::ST_D_K0:
            begin
                is_mul  = 1'b0;
                is_div  = 1'b1;
                div_num = signed'({1'b0, q00_reg});
            end
            kabf_pkg::ST_D_K1:
            begin
                is_mul  = 1'b0;
                is_div  = 1'b1;
                div_num = kabf_pkg::NUM_W'(q10_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_start = is_mul && !launched_reg;
        div_start = is_div && !launched_reg;
    end

    kabf_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .rsp   (mul_rsp)
    );

    kabf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .rsp   (div_rsp)
    );

    assign mres = kabf_pkg::sxr(mul_rsp.res);

    // Step sequencer: each step launches its unit once and writes back when it is done.
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        z_next         = z_reg;
        rate_next      = rate_reg;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        p00_next       = p00_reg;
        p01_next       = p01_reg;
        p10_next       = p10_reg;
        p11_next       = p11_reg;
        angle_p_next   = angle_p_reg;
        t11_next       = t11_reg;
        acc_next       = acc_reg;
        q00_next       = q00_reg;
        q01_next       = q01_reg;
        q10_next       = q10_reg;
        q11_next       = q11_reg;
        s_next         = s_reg;
        innov_next     = innov_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_angle_next = out_angle_reg;
        out_rate_next  = out_rate_reg;

        if (mul_start || div_start)
            launched_next = 1'b1;
        if ((is_mul && mul_rsp.done) || (is_div && div_rsp.done))
            launched_next = 1'b0;

        unique case (state_reg)
            kabf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    z_next     = measured_angle;
                    rate_next  = rate_sample;
                    state_next = kabf_pkg::ST_M_RATE;
                end
            end
            kabf_pkg::ST_M_RATE:
            begin
                if (mul_rsp.done)
                begin
                    angle_p_next = kabf_pkg::sat_s32(kabf_pkg::sx32(angle_reg) + mres);
                    state_next   = kabf_pkg::ST_M_T11;
                end
            end
            kabf_pkg::ST_M_T11:
            begin
                if (mul_rsp.done)
                begin
                    t11_next   = mul_rsp.res[kabf_pkg::OP_W-1:0];
                    state_next = kabf_pkg::ST_M_CROSS;
                end
            end
            kabf_pkg::ST_M_CROSS:
            begin
                if (mul_rsp.done)
                begin
                    acc_next   = kabf_pkg::zx32(p00_reg) - mres;
                    state_next = kabf_pkg::ST_M_DT11;
                end
            end
            kabf_pkg::ST_M_DT11:
            begin
                if (mul_rsp.done)
                begin
                    acc_next   = acc_reg + mres;
                    state_next = kabf_pkg::ST_ADD;
                end
            end
            kabf_pkg::ST_ADD:
            begin
                // Predicted covariance with process noise on the diagonal.
                q00_next   = kabf_pkg::sat_u32(acc_reg + kabf_pkg::zx32(cfg_reg.angle_q));
                q01_next   = kabf_pkg::sat_s32(kabf_pkg::sx32(p01_reg)
                                               - kabf_pkg::ACC_W'(t11_reg));
                q10_next   = kabf_pkg::sat_s32(kabf_pkg::sx32(p10_reg)
                                               - kabf_pkg::ACC_W'(t11_reg));
                q11_next   = kabf_pkg::sat_u32(kabf_pkg::zx32(p11_reg)
                                               + kabf_pkg::zx32(cfg_reg.bias_q));
                state_next = kabf_pkg::ST_PREP;
            end
            kabf_pkg::ST_PREP:
            begin
                s_next     = {1'b0, q00_reg} + {1'b0, cfg_reg.meas_r};
                innov_next = 33'(z_reg) - 33'(angle_p_reg);
                state_next = kabf_pkg::ST_D_K0;
            end
            kabf_pkg::ST_D_K0:
            begin
                if (div_rsp.done)
                begin
                    k0_next    = div_rsp.res;
                    state_next = kabf_pkg::ST_D_K1;
                end
            end
            kabf_pkg::ST_D_K1:
            begin
                if (div_rsp.done)
                begin
                    k1_next    = div_rsp.res;
                    state_next = kabf_pkg::ST_M_ANG;
                end
            end
            kabf_pkg::ST_M_ANG:
            begin
                if (mul_rsp.done)
                begin
                    angle_next = kabf_pkg::sat_s32(kabf_pkg::sx32(angle_p_reg) + mres);
                    state_next = kabf_pkg::ST_M_BIAS;
                end
            end
            kabf_pkg::ST_M_BIAS:
            begin
                if (mul_rsp.done)
                begin
                    bias_next  = kabf_pkg::sat_s32(kabf_pkg::sx32(bias_reg) + mres);
                    state_next = kabf_pkg::ST_M_P00;
                end
            end
            kabf_pkg::ST_M_P00:
            begin
                if (mul_rsp.done)
                begin
                    p00_next   = kabf_pkg::sat_u32(kabf_pkg::zx32(q00_reg) - mres);
                    state_next = kabf_pkg::ST_M_P01;
                end
            end
            kabf_pkg::ST_M_P01:
            begin
                if (mul_rsp.done)
                begin
                    p01_next   = kabf_pkg::sat_s32(kabf_pkg::sx32(q01_reg) - mres);
                    state_next = kabf_pkg::ST_M_P10;
                end
            end
            kabf_pkg::ST_M_P10:
            begin
                if (mul_rsp.done)
                begin
                    p10_next   = kabf_pkg::sat_s32(kabf_pkg::sx32(q10_reg) - mres);
                    state_next = kabf_pkg::ST_M_P11;
                end
            end
            kabf_pkg::ST_M_P11:
            begin
                if (mul_rsp.done)
                begin
                    p11_next   = kabf_pkg::sat_u32(kabf_pkg::zx32(q11_reg) - mres);
                    state_next = kabf_pkg::ST_OUT;
                end
            end
            kabf_pkg::ST_OUT:
            begin
                // Wait for room in the output register.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_angle_next = angle_reg;
                    out_rate_next  = kabf_pkg::sat_s32(kabf_pkg::sx32(rate_reg)
                                                       - kabf_pkg::sx32(bias_reg));
                    state_next     = kabf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next    = kabf_pkg::ST_IDLE;
                launched_next = 1'b0;
            end
        endcase
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kabf_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            p00_reg       <= kabf_pkg::ONE_Q8_24;
            p01_reg       <= '0;
            p10_reg       <= '0;
            p11_reg       <= kabf_pkg::ONE_Q8_24;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            p00_reg       <= p00_next;
            p01_reg       <= p01_next;
            p10_reg       <= p10_next;
            p11_reg       <= p11_next;
        end
    end

    // Working values of the current step.
    always_ff @(posedge clk)
    begin
        z_reg         <= z_next;
        rate_reg      <= rate_next;
        angle_p_reg   <= angle_p_next;
        t11_reg       <= t11_next;
        acc_reg       <= acc_next;
        q00_reg       <= q00_next;
        q01_reg       <= q01_next;
        q10_reg       <= q10_next;
        q11_reg       <= q11_next;
        s_reg         <= s_next;
        innov_reg     <= innov_next;
        k0_reg        <= k0_next;
        k1_reg        <= k1_next;
        out_angle_reg <= out_angle_next;
        out_rate_reg  <= out_rate_next;
    end

    assign in_stall       = (state_reg != kabf_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign angle_estimate = out_angle_reg;
    assign corrected_rate = out_rate_reg;

endmodule

>>> hdl/kabf_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed multiplier giving (a*b) >> 16, rounded half away from zero.
module kabf_mul
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [kabf_pkg::OP_W-1:0]       a,
    input  logic signed [kabf_pkg::OP_W-1:0]       b,
    output kabf_pkg::mul_rsp_t                     rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MAG  = 4'b0010,
        M_RUN  = 4'b0100,
        M_FIN  = 4'b1000
    } mul_state_t;

    localparam int CNT_W = $clog2(kabf_pkg::MAG_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(kabf_pkg::MAG_W - 1);

    mul_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic signed [kabf_pkg::OP_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [kabf_pkg::MAG_W-1:0] amag_reg, amag_next, bmag_reg, bmag_next;
    logic neg_reg, neg_next;
    logic [kabf_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic signed [kabf_pkg::RES_W-1:0] res_reg, res_next;
    logic [kabf_pkg::MAG_W:0] sum;
    logic [kabf_pkg::RES_W-1:0] rounded;

    // One partial product per cycle into the upper half, then shift right.
    always_comb
    begin
        sum = {1'b0, acc_reg[kabf_pkg::PROD_W-1:kabf_pkg::MAG_W]}
            + (bmag_reg[0] ? {1'b0, amag_reg} : '0);
        rounded = {1'b0, acc_reg[kabf_pkg::PROD_W-1:kabf_pkg::FRAC_W]};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        amag_next  = amag_reg;
        bmag_next  = bmag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    state_next = M_MAG;
                end
            end
            M_MAG:
            begin
                // The rounding constant is preloaded where the shifts bring it to bit 15.
                amag_next  = a_reg[kabf_pkg::OP_W-1] ? kabf_pkg::MAG_W'(-a_reg)
                                                     : kabf_pkg::MAG_W'(a_reg);
                bmag_next  = b_reg[kabf_pkg::OP_W-1] ? kabf_pkg::MAG_W'(-b_reg)
                                                     : kabf_pkg::MAG_W'(b_reg);
                neg_next   = a_reg[kabf_pkg::OP_W-1] ^ b_reg[kabf_pkg::OP_W-1];
                acc_next   = kabf_pkg::PROD_W'(1) << (kabf_pkg::MAG_W + kabf_pkg::FRAC_W - 1);
                cnt_next   = '0;
                state_next = M_RUN;
            end
            M_RUN:
            begin
                acc_next  = {sum, acc_reg[kabf_pkg::MAG_W-1:1]};
                bmag_next = bmag_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    state_next = M_FIN;
            end
            M_FIN:
            begin
                res_next   = neg_reg ? -signed'(rounded) : signed'(rounded);
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        amag_reg <= amag_next;
        bmag_reg <= bmag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

>>> hdl/kabf_div.sv
`timescale 1ns / 1ps
// Restoring bit-serial divider forming a saturated Q16.16 gain from two Q8.24 values.
module kabf_div
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [kabf_pkg::NUM_W-1:0]      num,
    input  logic [kabf_pkg::DEN_W-1:0]             den,
    output kabf_pkg::div_rsp_t                     rsp
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MAG  = 5'b00010,
        D_PREP = 5'b00100,
        D_RUN  = 5'b01000,
        D_FIN  = 5'b10000
    } div_state_t;

    localparam int CNT_W = $clog2(kabf_pkg::DIV_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(kabf_pkg::DIV_W - 1);
    localparam logic [kabf_pkg::DIV_W-1:0] POS_MAX = kabf_pkg::DIV_W'(32'h7FFF_FFFF);
    localparam logic [kabf_pkg::DIV_W-1:0] NEG_MAX = kabf_pkg::DIV_W'(32'h8000_0000);

    div_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic signed [kabf_pkg::NUM_W-1:0] num_reg, num_next;
    logic [kabf_pkg::DEN_W-1:0] den_reg, den_next;
    logic [kabf_pkg::NUM_W-1:0] nmag_reg, nmag_next;
    logic neg_reg, neg_next;
    logic [kabf_pkg::DIV_W-1:0] work_reg, work_next;
    logic [kabf_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic signed [31:0] res_reg, res_next;
    logic [kabf_pkg::DEN_W:0] trial;
    logic [kabf_pkg::DEN_W:0] diff;
    logic [31:0] qclip;

    // One quotient bit per cycle.
    always_comb
    begin
        trial = {rem_reg, work_reg[kabf_pkg::DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (neg_reg)
            qclip = (work_reg > NEG_MAX) ? NEG_MAX[31:0] : work_reg[31:0];
        else
            qclip = (work_reg > POS_MAX) ? POS_MAX[31:0] : work_reg[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        den_next   = den_reg;
        nmag_next  = nmag_reg;
        neg_next   = neg_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_next   = num;
                    den_next   = den;
                    state_next = D_MAG;
                end
            end
            D_MAG:
            begin
                nmag_next  = num_reg[kabf_pkg::NUM_W-1] ? kabf_pkg::NUM_W'(-num_reg)
                                                        : kabf_pkg::NUM_W'(num_reg);
                neg_next   = num_reg[kabf_pkg::NUM_W-1];
                state_next = D_PREP;
            end
            D_PREP:
            begin
                // Half the divisor is added so that truncation rounds to nearest.
                work_next  = {nmag_reg, {kabf_pkg::FRAC_W{1'b0}}}
                           + kabf_pkg::DIV_W'(den_reg >> 1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = D_RUN;
            end
            D_RUN:
            begin
                if (!diff[kabf_pkg::DEN_W])
                begin
                    rem_next  = diff[kabf_pkg::DEN_W-1:0];
                    work_next = {work_reg[kabf_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[kabf_pkg::DEN_W-1:0];
                    work_next = {work_reg[kabf_pkg::DIV_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    state_next = D_FIN;
            end
            D_FIN:
            begin
                // A zero denominator gives a zero gain.
                if (den_reg == '0)
                    res_next = '0;
                else if (neg_reg)
                    res_next = signed'(32'd0 - qclip);
                else
                    res_next = signed'(qclip);
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        nmag_reg <= nmag_next;
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

>>> hdl/kabf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the angle and bias filter, bound to the top level.
module kabf_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] angle_estimate,
    input logic signed [31:0] corrected_rate
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle_estimate))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(corrected_rate))
        else $error("stalled corrected rate changed");

    // An accepted beat keeps the input side stalled while the step runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the step ran");

    // A new result only appears after a step was under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a step");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-state angle and gyro bias filter.
module tb_top;

    localparam int  CLK_HALF   = 6;
    localparam int  DRAIN_WAIT = 600;
    localparam longint CYCLE_LIMIT = 6000000;

    // One expected output beat.
    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } filter_output_t;

    // Tracks the filter state alongside the block and checks every output beat.
    class filter_scoreboard;
        logic [kabf_pkg::PER_W-1:0] period;
        logic [31:0]      angle_q;
        logic [31:0]      bias_q;
        logic [31:0]      meas_r;
        longint           angle_est;
        longint           bias_est;
        longint           p00, p01, p10, p11;
        filter_output_t   expected_outputs[$];
        int               failures;
        int               inputs_seen;
        int               outputs_seen;
        int               zero_gain_steps;

        function new();
            period    = kabf_pkg::PERIOD_RST;
            angle_q   = kabf_pkg::ANGLE_Q_RST;
            bias_q    = kabf_pkg::BIAS_Q_RST;
            meas_r    = kabf_pkg::MEAS_R_RST;
            angle_est = 0;
            bias_est  = 0;
            p00       = kabf_pkg::ONE_Q8_24;
            p01       = 0;
            p10       = 0;
            p11       = kabf_pkg::ONE_Q8_24;
            failures  = 0;
            inputs_seen = 0;
            outputs_seen = 0;
            zero_gain_steps = 0;
        endfunction

        function void write_reg(kabf_pkg::cfg_index_t idx, logic [31:0] data);
            case (idx)
                kabf_pkg::REG_PERIOD:  period  = data[kabf_pkg::PER_W-1:0];
                kabf_pkg::REG_ANGLE_Q: angle_q = data;
                kabf_pkg::REG_BIAS_Q:  bias_q  = data;
                kabf_pkg::REG_MEAS_R:  meas_r  = data;
                default: ;
            endcase
        endfunction

        static function longint clamp_s32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function longint clamp_u32(longint v);
            if (v < 0) return 0;
            if (v > 64'sd4294967295) return 64'sd4294967295;
            return v;
        endfunction

        static function longint unsigned abs64(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // Fixed-point product shifted down by 16, rounded half away from zero.
        static function longint fx_mul(longint a, longint b);
            longint unsigned p;
            p = abs64(a) * abs64(b);
            p = (p + 64'd32768) >> 16;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        endfunction

        // Gain as a Q16.16 ratio, rounded half away from zero, saturated; zero for a zero denominator.
        static function longint fx_gain(longint num, longint unsigned den);
            longint unsigned q;
            if (den == 0) return 0;
            q = ((abs64(num) << 16) + den / 2) / den;
            if (num < 0)
            begin
                if (q > 64'h8000_0000) q = 64'h8000_0000;
                return -longint'(q);
            end
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            return longint'(q);
        endfunction

        // Runs one filter step for an accepted input beat and queues its output.
        function void note_input(logic signed [31:0] z_in, logic signed [31:0] rate_in);
            longint z, rate, dt, angle_p, t11, q00, q01, q10, q11, k0, k1, innov;
            longint unsigned den;
            filter_output_t res;
            z    = z_in;
            rate = rate_in;
            dt   = period;
            // Prediction.
            angle_p = clamp_s32(angle_est + fx_mul(dt, rate - bias_est));
            t11 = fx_mul(dt, p11);
            q00 = clamp_u32(p00 - fx_mul(dt, p01 + p10) + fx_mul(dt, t11) + longint'(angle_q));
            q01 = clamp_s32(p01 - t11);
            q10 = clamp_s32(p10 - t11);
            q11 = clamp_u32(p11 + longint'(bias_q));
            // Gains.
            den = longint'(q00) + longint'(meas_r);
            if (den == 0) zero_gain_steps++;
            k0 = fx_gain(q00, den);
            k1 = fx_gain(q10, den);
            // Correction.
            innov = z - angle_p;
            angle_est = clamp_s32(angle_p + fx_mul(k0, innov));
            bias_est  = clamp_s32(bias_est + fx_mul(k1, innov));
            p00 = clamp_u32(q00 - fx_mul(k0, q00));
            p01 = clamp_s32(q01 - fx_mul(k0, q01));
            p10 = clamp_s32(q10 - fx_mul(k1, q00));
            p11 = clamp_u32(q11 - fx_mul(k1, q01));
            res.angle = angle_est[31:0];
            res.rate  = 32'(clamp_s32(rate - bias_est));
            expected_outputs.push_back(res);
            inputs_seen++;
        endfunction

        function void check_result(logic signed [31:0] angle, logic signed [31:0] rate);
            filter_output_t exp_out;
            outputs_seen++;
            if (expected_outputs.size() == 0)
            begin
                $error("output beat with no expected result: angle %0d rate %0d", angle, rate);
                failures++;
                return;
            end
            exp_out = expected_outputs.pop_front();
            if (angle !== exp_out.angle)
            begin
                $error("angle_estimate mismatch: expected %0d, got %0d", exp_out.angle, angle);
                failures++;
            end
            if (rate !== exp_out.rate)
            begin
                $error("corrected_rate mismatch: expected %0d, got %0d", exp_out.rate, rate);
                failures++;
            end
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] measured_angle;
    logic signed [31:0] rate_sample;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] corrected_rate;
    logic               cfg_valid;
    logic               cfg_ready;
    kabf_pkg::cfg_index_t cfg_index;
    logic [31:0]        cfg_data;

    filter_scoreboard sb;
    int     send_idle_pct;
    int     stall_pct;
    longint cycle_count;
    logic signed [31:0] track_angle;

    kalman_angle_bias_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured_angle (measured_angle),
        .rate_sample    (rate_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_estimate (angle_estimate),
        .corrected_rate (corrected_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Monitors: every beat and register write is seen with pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(measured_angle, rate_sample);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(angle_estimate, corrected_rate);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one input beat, with random idle cycles ahead of it.
    task automatic send_sample(logic signed [31:0] z, logic signed [31:0] rate);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        measured_angle <= z;
        rate_sample    <= rate;
        do @(posedge clk); while (in_stall);
    endtask

    // Holds one register write until it is taken; the caller lowers valid afterwards.
    task automatic write_reg(kabf_pkg::cfg_index_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Lets the block go idle before the configuration changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] per, logic [31:0] aq, logic [31:0] bq,
                             logic [31:0] r);
        drain();
        write_reg(kabf_pkg::REG_PERIOD, per);
        write_reg(kabf_pkg::REG_ANGLE_Q, aq);
        write_reg(kabf_pkg::REG_BIAS_Q, bq);
        write_reg(kabf_pkg::REG_MEAS_R, r);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a slowly moving angle with a modest rate; sometimes full-range noise or near-extreme values.
    task automatic send_random();
        logic signed [31:0] z, rate;
        int mode;
        mode = $urandom_range(99);
        if (mode < 70)
        begin
            track_angle = track_angle + $signed($urandom_range(8192)) - 4096;
            z    = track_angle + $signed($urandom_range(2048)) - 1024;
            rate = $signed($urandom_range(1 << 20)) - (1 << 19);
        end
        else if (mode < 85)
        begin
            z    = $urandom;
            rate = $urandom;
        end
        else
        begin
            z    = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(15)
                                     : 32'sh8000_0000 + $urandom_range(15);
            rate = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        send_sample(z, rate);
    endtask

    initial
    begin
        logic [31:0] settings[8][4];
        int phase, n, per_phase;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        measured_angle = '0;
        rate_sample = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = kabf_pkg::REG_PERIOD;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        track_angle = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under the reset configuration.
        send_sample(32'sd0, 32'sd0);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(-32'sd1, 32'sd1);
        send_sample(32'sd65536, -32'sd65536);

        // Directed: zero period, no angle noise and zero measurement noise
        // drive P00 to zero, after which the gain denominator is zero.
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(32'sd100000, 32'sd5000);
        send_sample(-32'sd100000, -32'sd5000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'sd0, 32'sd0);

        // Directed: largest period with tiny measurement noise pushes the bias gain
        // into saturation and the variances towards their clamps.
        configure(32'h0001_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sd12345, -32'sd54321);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);
        configure(32'd65536, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'sd1, -32'sd1);
        send_sample(32'sh7FFF_FFFF, 32'sd0);

        // Random phases over a range of settings and handshake pressure.
        settings[0] = '{32'd655, 32'd16777, 32'd16777, 32'd335544320};
        settings[1] = '{32'd1, 32'd0, 32'd0, 32'd1};
        settings[2] = '{32'h0001_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        settings[3] = '{32'd0, 32'd0, 32'd0, 32'd0};
        settings[4] = '{32'd65536, 32'd1677721, 32'd167, 32'd16777216};
        settings[5] = '{32'd6554, 32'd0, 32'hFFFF_FFFF, 32'd1};
        settings[6] = '{$urandom_range(32'h1FFFF), $urandom, $urandom, $urandom};
        settings[7] = '{32'd655, 32'd16777, 32'd16777, 32'd335544320};
        per_phase = 205;
        for (phase = 0; phase < 8; phase++)
        begin
            configure(settings[phase][0], settings[phase][1],
                      settings[phase][2], settings[phase][3]);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct = 12;
                end
            endcase
            for (n = 0; n < per_phase; n++)
                send_random();
        end

        // Wind-down.
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d input beats and %0d output beats over a dozen setups,",
                 sb.inputs_seen, sb.outputs_seen);
        $display("%0d steps with a zero gain denominator, under four handshake patterns.",
                 sb.zero_gain_steps);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/kabf_pkg.sv
hdl/kabf_mul.sv
hdl/kabf_div.sv
hdl/kalman_angle_bias_filter.sv
hdl/kabf_checker.sv
test/tb_top.sv
